### rtl/cpd_pkg.sv
package cpd_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int RSP_DATA_WIDTH  = 120;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_SECOND = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_FIRST    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_SECOND   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRC_SEED     = 3'd4;

   localparam logic [15:0] CRC_POLY = 16'h8408;

   localparam logic [2:0] HDR_START_POS = 3'd3;
   localparam logic [2:0] HDR_CMD_POS   = 3'd5;
   localparam logic [2:0] HDR_LAST_POS  = 3'd7;
   localparam logic [2:0] ARG_LAST_POS  = 3'd3;
   localparam logic [2:0] FTR_CRC_POS   = 3'd1;
   localparam logic [2:0] FTR_LAST_POS  = 3'd5;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_ARGS   = 3'b010,
      PH_FOOTER = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_ARG    = 2'd1,
      KIND_END    = 2'd2
   } kind_type;

   typedef struct packed {
      phase_type   section;
      logic [2:0]  pos;
      logic [7:0]  data;
   } tag_type;

   typedef struct packed {
      logic [15:0] start_first;
      logic [15:0] start_second;
      logic [15:0] end_first;
      logic [15:0] end_second;
      logic [15:0] crc_seed;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] opcode;
      logic [15:0] argument_total;
      logic [15:0] argument_index;
      logic [31:0] argument_value;
      logic        start_ok;
      logic        crc_ok;
      logic        end_ok;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
      logic        packet_last;
   } result_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### rtl/cpd_classifier.sv
module cpd_classifier (
   input  logic            clock,
   input  logic            reset,
   input  logic            byte_valid,
   input  logic [7:0]      byte_data,
   output cpd_pkg::tag_type tag
);

   cpd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         pos_ff, pos_in;
   logic [7:0]         prev_ff;
   logic [15:0]        exp_ff, exp_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic [15:0]        cnt_inc;
   logic [15:0]        count_word;

   assign cnt_inc    = cnt_ff + 16'd1;
   assign count_word = {prev_ff, byte_data};

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      exp_in      = exp_ff;
      cnt_in      = cnt_ff;
      tag.data    = byte_data;
      tag.pos     = pos_ff;
      tag.section = cpd_pkg::PH_HEADER;
      unique case (phase_ff)
         cpd_pkg::PH_ARGS: begin
            tag.section = cpd_pkg::PH_ARGS;
            if (pos_ff == cpd_pkg::ARG_LAST_POS) begin
               pos_in = 3'd0;
               cnt_in = cnt_inc;
               if (cnt_inc == exp_ff) begin
                  phase_in = cpd_pkg::PH_FOOTER;
               end
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
         cpd_pkg::PH_FOOTER: begin
            tag.section = cpd_pkg::PH_FOOTER;
            if (pos_ff == cpd_pkg::FTR_LAST_POS) begin
               pos_in   = 3'd0;
               phase_in = cpd_pkg::PH_HEADER;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
         default: begin
            phase_in = cpd_pkg::PH_HEADER;
            if (pos_ff == cpd_pkg::HDR_LAST_POS) begin
               pos_in   = 3'd0;
               exp_in   = count_word;
               cnt_in   = 16'd0;
               phase_in = (count_word == 16'd0) ? cpd_pkg::PH_FOOTER : cpd_pkg::PH_ARGS;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cpd_pkg::PH_HEADER;
         pos_ff   <= 3'd0;
         prev_ff  <= 8'd0;
         exp_ff   <= 16'd0;
         cnt_ff   <= 16'd0;
      end else if (byte_valid) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         prev_ff  <= byte_data;
         exp_ff   <= exp_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### rtl/cpd_queue.sv
module cpd_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cpd_pkg::tag_type push_tag,
   output logic             push_ready,
   input  logic             pop,
   output logic             head_valid,
   output cpd_pkg::tag_type head_tag
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cpd_pkg::tag_type mem [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_tag   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/cpd_executor.sv
module cpd_executor (
   input  logic                clock,
   input  logic                reset,
   input  cpd_pkg::cfg_type    cfg,
   input  logic                head_valid,
   input  cpd_pkg::tag_type    head_tag,
   output logic                pop,
   output logic                result_valid,
   input  logic                result_ready,
   output cpd_pkg::result_type result
);

   logic [31:0]         word_ff, word_in;
   logic [15:0]         crc_ff, crc_in;
   logic [15:0]         crc_base;
   logic [15:0]         cmd_ff, cmd_in;
   logic [15:0]         exp_ff, exp_in;
   logic [15:0]         done_ff, done_in;
   logic                start_ff, start_in;
   logic [15:0]         fcrc_ff, fcrc_in;
   logic                emit;
   cpd_pkg::result_type res_next;
   logic                valid_ff, valid_in;
   cpd_pkg::result_type res_ff;

   assign pop          = head_valid && (!valid_ff || result_ready);
   assign word_in      = {word_ff[23:0], head_tag.data};
   assign crc_base     = (head_tag.pos == 3'd0) ? cfg.crc_seed : crc_ff;
   assign result_valid = valid_ff;
   assign result       = res_ff;

   always_comb begin
      crc_in   = crc_ff;
      cmd_in   = cmd_ff;
      exp_in   = exp_ff;
      done_in  = done_ff;
      start_in = start_ff;
      fcrc_in  = fcrc_ff;
      emit     = 1'b0;
      res_next = '0;
      unique case (head_tag.section)
         cpd_pkg::PH_ARGS: begin
            crc_in = cpd_pkg::crc_byte(crc_ff, head_tag.data);
            if (head_tag.pos == cpd_pkg::ARG_LAST_POS) begin
               emit                    = 1'b1;
               done_in                 = done_ff + 16'd1;
               res_next.kind           = cpd_pkg::KIND_ARG;
               res_next.opcode         = cmd_ff;
               res_next.argument_total = exp_ff;
               res_next.argument_index = done_ff;
               res_next.argument_value = word_in;
               res_next.start_ok       = start_ff;
            end
         end
         cpd_pkg::PH_FOOTER: begin
            if (head_tag.pos == cpd_pkg::FTR_CRC_POS) begin
               fcrc_in = word_in[15:0];
            end
            if (head_tag.pos == cpd_pkg::FTR_LAST_POS) begin
               emit                    = 1'b1;
               res_next.kind           = cpd_pkg::KIND_END;
               res_next.opcode         = cmd_ff;
               res_next.argument_total = exp_ff;
               res_next.start_ok       = start_ff;
               res_next.crc_ok         = fcrc_ff == crc_ff;
               res_next.end_ok         = (word_in[31:16] == cfg.end_first) &&
                                         (word_in[15:0] == cfg.end_second);
               res_next.received_crc   = fcrc_ff;
               res_next.computed_crc   = crc_ff;
               res_next.packet_last    = 1'b1;
            end
         end
         default: begin
            crc_in = cpd_pkg::crc_byte(crc_base, head_tag.data);
            if (head_tag.pos == cpd_pkg::HDR_START_POS) begin
               start_in = (word_in[31:16] == cfg.start_first) &&
                          (word_in[15:0] == cfg.start_second);
            end
            if (head_tag.pos == cpd_pkg::HDR_CMD_POS) begin
               cmd_in = word_in[15:0];
            end
            if (head_tag.pos == cpd_pkg::HDR_LAST_POS) begin
               emit                    = 1'b1;
               exp_in                  = word_in[15:0];
               done_in                 = 16'd0;
               res_next.kind           = cpd_pkg::KIND_HEADER;
               res_next.opcode         = cmd_ff;
               res_next.argument_total = word_in[15:0];
               res_next.start_ok       = start_ff;
            end
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop && emit) begin
         valid_in = 1'b1;
      end else if (result_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         res_ff <= res_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         word_ff  <= 32'd0;
         crc_ff   <= 16'd0;
         cmd_ff   <= 16'd0;
         exp_ff   <= 16'd0;
         done_ff  <= 16'd0;
         start_ff <= 1'b0;
         fcrc_ff  <= 16'd0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            word_ff  <= word_in;
            crc_ff   <= crc_in;
            cmd_ff   <= cmd_in;
            exp_ff   <= exp_in;
            done_ff  <= done_in;
            start_ff <= start_in;
            fcrc_ff  <= fcrc_in;
         end
      end
   end

endmodule

### rtl/command_packet_deframer.sv
// Result path: with the tag queue empty, the word completing a result is stored in the tag queue
// and then in the executor's result register, which raises rsp_tvalid for the rsp handshake.
// Throughput: one stream word per cycle, sustained while rsp_tready stays high; while a result
// waits on the rsp side, the queue takes up to QUEUE_DEPTH more words before req_tready falls.
// Reset: synchronous, active high; clears the configuration registers, the queue, the result valid flag and
// the parser, which then waits for the first header word of a packet.
module command_packet_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // stream_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // opcode, argument_total, argument_index, argument_value, start_ok, crc_ok,
   // end_ok, received_crc, computed_crc, zero fill
   output logic [cpd_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic [1:0]                           rsp_tuser,   // result_kind
   output logic                                 rsp_tlast,   // packet_last
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cpd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [cpd_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   cpd_pkg::cfg_type    cfg_ff;
   cpd_pkg::tag_type    front_tag;
   cpd_pkg::tag_type    head_tag;
   cpd_pkg::result_type result;
   logic                req_accept;
   logic                head_valid;
   logic                head_pop;

   assign csr_ready  = 1'b1;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            cpd_pkg::CSR_START_FIRST:  cfg_ff.start_first  <= csr_data;
            cpd_pkg::CSR_START_SECOND: cfg_ff.start_second <= csr_data;
            cpd_pkg::CSR_END_FIRST:    cfg_ff.end_first    <= csr_data;
            cpd_pkg::CSR_END_SECOND:   cfg_ff.end_second   <= csr_data;
            cpd_pkg::CSR_CRC_SEED:     cfg_ff.crc_seed     <= csr_data;
            default:                   cfg_ff              <= cfg_ff;
         endcase
      end
   end

   cpd_classifier u_classifier (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_accept),
      .byte_data  (req_tdata),
      .tag        (front_tag)
   );

   cpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_tag   (front_tag),
      .push_ready (req_tready),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_tag   (head_tag)
   );

   cpd_executor u_executor (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head_tag     (head_tag),
      .pop          (head_pop),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready),
      .result       (result)
   );

   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.packet_last;
   assign rsp_tdata = {5'd0,
                       result.computed_crc,
                       result.received_crc,
                       result.end_ok,
                       result.crc_ok,
                       result.start_ok,
                       result.argument_value,
                       result.argument_index,
                       result.argument_total,
                       result.opcode};

   a_queue_holds_word: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> head_valid)
      else $error("accepted word missing from the tag queue");

   a_arg_position: assert property (@(posedge clock) disable iff (reset)
      (head_valid && head_tag.section == cpd_pkg::PH_ARGS) |->
         head_tag.pos <= cpd_pkg::ARG_LAST_POS)
      else $error("argument byte position out of range");

   a_footer_position: assert property (@(posedge clock) disable iff (reset)
      (head_valid && head_tag.section == cpd_pkg::PH_FOOTER) |->
         head_tag.pos <= cpd_pkg::FTR_LAST_POS)
      else $error("footer byte position out of range");

   a_last_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == cpd_pkg::KIND_END)))
      else $error("tlast does not match the end result");

endmodule
